/* hw/rtl/ccbp_pkg.sv */
// ----------------------------------------------------------------------------
// ccbp_pkg
// shared types and constants of the coefficient compress bit packer
// ----------------------------------------------------------------------------
package ccbp_pkg;

    localparam int unsigned COEF_W   = 13;
    localparam int unsigned VAL_W    = 11;
    localparam int unsigned N_W      = 28;
    localparam int unsigned RECIP_W  = 29;
    localparam int unsigned PROD_W   = N_W + RECIP_W;
    localparam int unsigned QUO_W    = 17;
    localparam int unsigned RECIP_SH = 40;

    localparam logic [11:0] MOD_Q    = 12'd3329;
    localparam logic [10:0] HALF_Q   = 11'd1664;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SH) / 64'd3329);

    localparam logic [3:0] CBITS_RESET = 4'd10;
    localparam logic [3:0] CBITS_WIDE  = 4'd11;

    localparam int unsigned QUEUE_DEPTH_DEF = 8;

    typedef struct packed {
        logic             mode11;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

/* hw/rtl/ccbp_front.sv */
// ----------------------------------------------------------------------------
// ccbp_front
// maps coefficients in -q..q-1 into 0..q-1, compresses by reciprocal multiply
// ----------------------------------------------------------------------------
module ccbp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ccbp_pkg::COEF_W-1:0]   i_coef,
    input  logic                          i_mode11,
    output logic                          o_valid,
    output ccbp_pkg::t_entry              o_entry
);
    import ccbp_pkg::*;

    logic [16:0]       w_sum;
    logic [15:0]       w_x;
    logic [26:0]       w_xsh;
    logic [N_W-1:0]    w_n;

    logic              r1_v, r2_v, r3_v;
    logic              r1_m, r2_m, r3_m;
    logic [N_W-1:0]    r1_n, r2_n, r3_n;
    logic [PROD_W-1:0] r2_prod;
    logic [QUO_W-1:0]  w_q0, r3_q0;
    logic [28:0]       r3_p;
    logic [28:0]       w_rem;
    logic [VAL_W-1:0]  w_q;

    always_comb begin
        w_sum = 17'({3'b111, i_coef}) + 17'(MOD_Q);
        w_x   = i_coef[COEF_W-1] ? w_sum[15:0] : {3'b000, i_coef};
        w_xsh = i_mode11 ? {w_x, 11'b0} : {1'b0, w_x, 10'b0};
        w_n   = N_W'(w_xsh) + N_W'(HALF_Q);
    end

    assign w_q0 = r2_prod[RECIP_SH +: QUO_W];

    always_comb begin
        w_rem = 29'(r3_n) - r3_p;
        w_q   = (w_rem >= 29'(MOD_Q)) ? (r3_q0[VAL_W-1:0] + VAL_W'(1)) : r3_q0[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_n    <= w_n;
        r1_m    <= i_mode11;
        r2_prod <= PROD_W'(r1_n) * PROD_W'(RECIP);
        r2_n    <= r1_n;
        r2_m    <= r1_m;
        r3_q0   <= w_q0;
        r3_p    <= 29'(w_q0) * 29'(MOD_Q);
        r3_n    <= r2_n;
        r3_m    <= r2_m;
    end

    assign o_valid        = r3_v;
    assign o_entry.mode11 = r3_m;
    assign o_entry.value  = r3_m ? w_q : {1'b0, w_q[VAL_W-2:0]};

endmodule

/* hw/rtl/ccbp_queue.sv */
// ----------------------------------------------------------------------------
// ccbp_queue
// small register fifo of compressed values between front and back
// ----------------------------------------------------------------------------
module ccbp_queue #(
    parameter int unsigned DEPTH = ccbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ccbp_pkg::t_entry  i_push_data,
    input  logic              i_pop,
    output ccbp_pkg::t_entry  o_pop_data,
    output logic              o_empty
);
    import ccbp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rptr];
    assign o_empty    = (r_cnt == '0);

endmodule

/* hw/rtl/ccbp_back.sv */
// ----------------------------------------------------------------------------
// ccbp_back
// appends compressed values to the bit accumulator and emits bytes
// ----------------------------------------------------------------------------
module ccbp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  ccbp_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last
);
    import ccbp_pkg::*;

    logic [6:0]  r_bits, n_bits;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_second, n_second;
    logic [7:0]  r_hold, n_hold;
    logic        r_out_v, n_out_v;
    logic [7:0]  r_out_b, n_out_b;
    logic        r_out_l, n_out_l;
    logic        w_adv;
    logic [17:0] w_acc;
    logic [4:0]  w_tot;

    assign w_adv = !r_out_v || i_ready;
    assign o_pop = w_adv && !r_second && !i_empty;

    always_comb begin
        w_acc    = 18'(r_bits) | (18'(i_entry.value) << r_cnt);
        w_tot    = 5'(r_cnt) + (i_entry.mode11 ? 5'd11 : 5'd10);
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_second = r_second;
        n_hold   = r_hold;
        n_out_v  = r_out_v;
        n_out_b  = r_out_b;
        n_out_l  = r_out_l;
        if (w_adv) begin
            if (r_second) begin
                n_out_v  = 1'b1;
                n_out_b  = r_hold;
                n_out_l  = 1'b1;
                n_second = 1'b0;
            end else if (!i_empty) begin
                n_out_v = 1'b1;
                n_out_b = w_acc[7:0];
                n_cnt   = w_tot[2:0];
                if (w_tot[4]) begin
                    n_out_l  = 1'b0;
                    n_hold   = w_acc[15:8];
                    n_bits   = {5'b0, w_acc[17:16]};
                    n_second = 1'b1;
                end else begin
                    n_out_l = 1'b1;
                    n_bits  = w_acc[14:8];
                end
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits   <= '0;
            r_cnt    <= '0;
            r_second <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_bits   <= n_bits;
            r_cnt    <= n_cnt;
            r_second <= n_second;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_out_b <= n_out_b;
        r_out_l <= n_out_l;
    end

    assign o_valid = r_out_v;
    assign o_byte  = r_out_b;
    assign o_last  = r_out_l;

endmodule

/* hw/rtl/coeff_compress_bit_packer_top.sv */
// ----------------------------------------------------------------------------
// coeff_compress_bit_packer_top
// compresses coefficients to 10 or 11 bits and packs them lsb first into bytes
//
//  channel   dir  transfer when                  payload
//  s_axis    in   i_s_axis_tvalid & tready       tdata[12:0] coefficient
//  m_axis    out  o_m_axis_tvalid & tready       tdata[7:0] packed byte, tlast
//  cfg       in   i_cfg_valid & o_cfg_ready      cfg_data[3:0] compressed bits
//
// a coefficient can be taken every cycle while tready is high; bytes leave one
// per cycle while the receiver is ready, and a two-byte coefficient holds off
// the next pop until its second byte is registered; input to first byte passes
// three compress stages, the queue write and the output register
// input tready drops once queue plus compress stages hold QUEUE_DEPTH items
// synchronous active-low reset clears the accumulator and sets 10-bit mode
// ----------------------------------------------------------------------------
module coeff_compress_bit_packer_top #(
    parameter int unsigned QUEUE_DEPTH = ccbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [12:0] coefficient
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] packed_byte
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import ccbp_pkg::*;

    localparam int unsigned USED_W = $clog2(QUEUE_DEPTH + 1);

    logic [3:0]        r_cbits;
    logic [USED_W-1:0] r_used, n_used;
    logic              w_in_xfer;
    logic              w_fr_valid;
    t_entry            w_fr_entry;
    t_entry            w_q_entry;
    logic              w_pop;
    logic              w_empty;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_used < USED_W'(QUEUE_DEPTH));
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbits <= CBITS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cbits <= i_cfg_data;
        end
    end

    always_comb begin
        n_used = r_used;
        if (w_in_xfer && !w_pop) begin
            n_used = r_used + USED_W'(1);
        end else if (!w_in_xfer && w_pop) begin
            n_used = r_used - USED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    ccbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_xfer),
        .i_coef   (i_s_axis_tdata[COEF_W-1:0]),
        .i_mode11 (r_cbits == CBITS_WIDE),
        .o_valid  (w_fr_valid),
        .o_entry  (w_fr_entry)
    );

    ccbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_fr_valid),
        .i_push_data (w_fr_entry),
        .i_pop       (w_pop),
        .o_pop_data  (w_q_entry),
        .o_empty     (w_empty)
    );

    ccbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(QUEUE_DEPTH))
        else $error("in-flight count exceeds queue depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("pop from empty queue");

    a_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
        |=> o_m_axis_tvalid && o_m_axis_tlast)
        else $error("second byte of a coefficient did not follow");

endmodule

/* sim/coeff_compress_bit_packer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coeff_compress_bit_packer_top_tb
// self-checking bench for the coefficient compress bit packer: coefficients are
// streamed in under several width settings and handshake pressure profiles, a
// bit-exact predictor builds the expected byte stream and every output byte is
// compared against it in order
// ----------------------------------------------------------------------------
module coeff_compress_bit_packer_top_tb;
    import ccbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS   = 180;

    typedef enum logic [1:0] {
        PRESS_NONE,
        PRESS_SENDER,
        PRESS_RECEIVER,
        PRESS_BOTH
    } t_pressure;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_run;
    } t_packed_byte;

    class t_packed_byte_tracker;
        t_packed_byte expected_bytes[$];
        logic [3:0]   width_sel = CBITS_RESET;
        logic [6:0]   carry_bits = '0;
        logic [2:0]   carry_count = '0;
        int unsigned  mismatches = 0;
        int unsigned  checked = 0;

        function void set_width(logic [3:0] cbits);
            width_sel = cbits;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void accept_coefficient(logic [12:0] coef);
            logic        wide;
            int unsigned nbits;
            logic [15:0] x;
            logic [31:0] scaled;
            logic [10:0] code;
            logic [17:0] acc;
            logic [4:0]  total;
            int unsigned n_out;
            t_packed_byte item;
            wide  = (width_sel == CBITS_WIDE);
            nbits = wide ? 11 : 10;
            // negative coefficients down to -q land in 0..q-1, lower ones wrap mod 2^16
            if (coef[12])
                x = {3'b111, coef} + 16'(MOD_Q);
            else
                x = {3'b000, coef};
            scaled = (32'(x) << nbits) + 32'(HALF_Q);
            code   = 11'(scaled / 32'(MOD_Q));
            if (!wide)
                code[10] = 1'b0;
            acc   = 18'(carry_bits) | (18'(code) << carry_count);
            total = 5'(carry_count) + 5'(nbits);
            n_out = (total >= 16) ? 2 : 1;
            for (int unsigned i = 0; i < n_out; i++) begin
                item.packed_byte = acc[7:0];
                item.last_of_run = (i == n_out - 1);
                expected_bytes.push_back(item);
                acc   = acc >> 8;
                total = total - 5'd8;
            end
            carry_bits  = acc[6:0];
            carry_count = total[2:0];
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte transfer: packed_byte %h last_of_run %b", data, last);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            if (data !== want.packed_byte) begin
                $error("packed_byte mismatch: expected %h actual %h", want.packed_byte, data);
                mismatches++;
            end
            if (last !== want.last_of_run) begin
                $error("last_of_run mismatch: expected %b actual %b", want.last_of_run, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // [12:0] coefficient
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [7:0] packed_byte
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;

    t_pressure            pressure = PRESS_NONE;
    t_packed_byte_tracker tracker = new();
    int unsigned          cycle_count = 0;
    int unsigned          sent_count = 0;
    int unsigned          width_writes = 0;

    logic [12:0] corner_coefs [12] = '{
        13'd0, 13'd1, -13'sd1, 13'd3328, -13'sd3328, 13'd1664,
        -13'sd1665, 13'd4095, -13'sd4096, 13'd3329, -13'sd3329, 13'd2
    };
    logic [3:0] phase_widths [8] = '{
        CBITS_WIDE, 4'd0, 4'd15, CBITS_RESET, CBITS_WIDE, 4'd12, 4'd1, CBITS_WIDE
    };

    coeff_compress_bit_packer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: check every byte transfer, then pick next cycle's tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_byte(o_m_axis_tdata, o_m_axis_tlast);
        case (pressure)
            PRESS_RECEIVER: i_m_axis_tready <= ($urandom_range(99) >= 66);
            PRESS_BOTH:     i_m_axis_tready <= ($urandom_range(99) >= 14);
            default:        i_m_axis_tready <= 1'b1;
        endcase
    end

    function automatic logic sender_gap();
        case (pressure)
            PRESS_SENDER: return ($urandom_range(99) < 66);
            PRESS_BOTH:   return ($urandom_range(99) < 14);
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic [12:0] random_coefficient();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return 13'(int'($urandom_range(6656)) - 3328);
        else if (pick < 92)
            return 13'(int'($urandom_range(7)) + ($urandom_range(1) ? 3321 : -3328));
        else
            return 13'($urandom);
    endfunction

    task automatic send_coefficient(input logic [12:0] coef);
        while (sender_gap()) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, coef};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.accept_coefficient(coef);
        sent_count++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [3:0] cbits);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cbits;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_width(cbits);
        width_writes++;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner coefficients in both widths
        write_width(CBITS_RESET);
        foreach (corner_coefs[i])
            send_coefficient(corner_coefs[i]);
        wait_drained();
        write_width(CBITS_WIDE);
        foreach (corner_coefs[i])
            send_coefficient(corner_coefs[i]);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            pressure <= t_pressure'(p % 4);
            write_width(phase_widths[p]);
            repeat (PHASE_ITEMS)
                send_coefficient(random_coefficient());
            wait_drained();
        end

        tracker.mismatches += tracker.pending();
        $display("run covered %0d coefficients and %0d packed bytes over %0d width writes",
                 sent_count, tracker.checked, width_writes);
        $display("selectors 0, 1, 10, 11, 12, 15 under four stall profiles");
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* coeff_compress_bit_packer_top.f */
hw/rtl/ccbp_pkg.sv
hw/rtl/ccbp_front.sv
hw/rtl/ccbp_queue.sv
hw/rtl/ccbp_back.sv
hw/rtl/coeff_compress_bit_packer_top.sv
sim/coeff_compress_bit_packer_top_tb.sv
